// ===== src/bds_pkg.sv =====
`default_nettype none

package bds_pkg;

  localparam int PIX_W        = 8;
  localparam int SUM_W        = PIX_W + 1;
  localparam int QUAD_W       = PIX_W + 2;
  localparam int CNT_W        = 11;
  localparam int SIZE_W       = 12;
  localparam int MAX_WIDTH    = 2048;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int ADDR_W       = $clog2(LINE_DEPTH);
  localparam int WIDTH_LIMIT  = (MAX_WIDTH / 2) * 2;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int CFG_IDX_W    = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_red;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic             frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pair_sum_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    pair_sum_t         data;
  } line_req_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] e;
    e = {v[SIZE_W-1:1], 1'b0};
    if (e < SIZE_W'(2)) e = SIZE_W'(2);
    if (e > limit) e = limit;
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== src/bds_line_store.sv =====
`default_nettype none

module bds_line_store (
  input  wire logic               clk,
  input  wire bds_pkg::line_req_t req,
  output bds_pkg::pair_sum_t      rd_data
);

  bds_pkg::pair_sum_t mem [bds_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/box_downscale_2x2_bgr_core.sv =====
// Channel  Direction  Signals                                Beat
// pixel    in         pixel_valid, pixel_ready, pixel        one BGR input pixel
// result   out        result_valid, result_ready, result     one half-size pixel
// cfg      in         cfg_valid, cfg_ready, cfg_index, cfg_data  one register write
//
// One pixel is taken per clock while pixel_ready is high; the pixel that completes
// a 2x2 block loads the stage register and the half-row store read, both feeding the result register.
// Reset clears the counters and the pipeline and restores a 640 by 480 frame.
// The pipeline keeps moving while the result register is empty or being taken,
// so a stalled output holds back the input only once both stages are full.
`default_nettype none

module box_downscale_2x2_bgr_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pixel_valid,
  output logic                                     pixel_ready,
  input  wire bds_pkg::pixel_in_t                  pixel,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output bds_pkg::pixel_out_t                      result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bds_pkg::SIZE_W-1:0]          cfg_data
);

  logic [bds_pkg::SIZE_W-1:0] width_eff;
  logic [bds_pkg::SIZE_W-1:0] height_eff;
  logic [bds_pkg::CNT_W-1:0]  column_count;
  logic [bds_pkg::CNT_W-1:0]  row_count;
  bds_pkg::pixel_in_t         left_pixel_hold;

  logic                       stage_valid;
  logic                       stage_end;
  bds_pkg::pair_sum_t         stage_sum;

  logic                       pixel_take;
  logic                       result_free;
  logic                       stage_move;
  logic                       col_odd;
  logic                       row_odd;
  logic [bds_pkg::SIZE_W-1:0] col_inc;
  logic [bds_pkg::SIZE_W-1:0] row_inc;
  logic                       last_pos;
  bds_pkg::pair_sum_t         pair_now;
  bds_pkg::line_req_t         line_req;
  bds_pkg::pair_sum_t         line_data;
  logic [bds_pkg::QUAD_W-1:0] quad_blue;
  logic [bds_pkg::QUAD_W-1:0] quad_green;
  logic [bds_pkg::QUAD_W-1:0] quad_red;

  assign cfg_ready   = 1'b1;
  assign result_free = !result_valid || result_ready;
  assign stage_move  = stage_valid && result_free;
  assign pixel_ready = !stage_valid || result_free;
  assign pixel_take  = pixel_valid && pixel_ready;

  assign col_odd = column_count[0];
  assign row_odd = row_count[0];
  assign col_inc = {1'b0, column_count} + bds_pkg::SIZE_W'(1);
  assign row_inc = {1'b0, row_count} + bds_pkg::SIZE_W'(1);
  assign last_pos = ({1'b0, column_count} == width_eff - bds_pkg::SIZE_W'(1)) &&
                    ({1'b0, row_count} == height_eff - bds_pkg::SIZE_W'(1));

  assign pair_now.blue  = {1'b0, pixel.in_blue}  + {1'b0, left_pixel_hold.in_blue};
  assign pair_now.green = {1'b0, pixel.in_green} + {1'b0, left_pixel_hold.in_green};
  assign pair_now.red   = {1'b0, pixel.in_red}   + {1'b0, left_pixel_hold.in_red};

  always_comb begin
    line_req.wr   = pixel_take && col_odd && !row_odd;
    line_req.rd   = pixel_take && col_odd && row_odd;
    line_req.addr = column_count[bds_pkg::ADDR_W:1];
    line_req.data = pair_now;
  end

  bds_line_store u_line_store (
    .clk     (clk),
    .req     (line_req),
    .rd_data (line_data)
  );

  assign quad_blue  = {1'b0, stage_sum.blue}  + {1'b0, line_data.blue};
  assign quad_green = {1'b0, stage_sum.green} + {1'b0, line_data.green};
  assign quad_red   = {1'b0, stage_sum.red}   + {1'b0, line_data.red};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= bds_pkg::WIDTH_RESET;
      height_eff <= bds_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bds_pkg::REG_FRAME_WIDTH: begin
          width_eff <= bds_pkg::eff_size(cfg_data, bds_pkg::SIZE_W'(bds_pkg::WIDTH_LIMIT));
        end
        bds_pkg::REG_FRAME_HEIGHT: begin
          height_eff <= bds_pkg::eff_size(cfg_data, bds_pkg::SIZE_W'(bds_pkg::HEIGHT_LIMIT));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      left_pixel_hold <= '0;
    end else if (pixel_take) begin
      if (!col_odd) begin
        left_pixel_hold <= pixel;
      end
      if (col_inc >= width_eff) begin
        column_count <= '0;
        if (row_inc >= height_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[bds_pkg::CNT_W-1:0];
        end
      end else begin
        column_count <= col_inc[bds_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pixel_take) begin
      stage_valid <= line_req.rd;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_req.rd) begin
      stage_sum <= pair_now;
      stage_end <= last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      result.out_blue  <= quad_blue[bds_pkg::QUAD_W-1:2];
      result.out_green <= quad_green[bds_pkg::QUAD_W-1:2];
      result.out_red   <= quad_red[bds_pkg::QUAD_W-1:2];
      result.frame_end <= stage_end;
    end
  end

endmodule

`default_nettype wire

// ===== tb/box_downscale_2x2_bgr_core_checker.sv =====
module box_downscale_2x2_bgr_core_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  input  logic                          pixel_ready,
  input  bds_pkg::pixel_in_t            pixel,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  bds_pkg::pixel_out_t           result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bds_pkg::SIZE_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            quads_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [bds_pkg::SIZE_W-1:0] width_reg = bds_pkg::WIDTH_RESET;
  logic [bds_pkg::SIZE_W-1:0] height_reg = bds_pkg::HEIGHT_RESET;
  logic [bds_pkg::CNT_W-1:0]  col = '0;
  logic [bds_pkg::CNT_W-1:0]  row = '0;
  bds_pkg::pixel_in_t         left_px = '0;
  bds_pkg::pair_sum_t         pair_line [bds_pkg::LINE_DEPTH];
  bds_pkg::pixel_out_t        expected_quads [$];
  int                         errors = 0;
  int                         pending_n = 0;
  int                         quads_seen = 0;

  assign fail_count    = errors;
  assign quads_pending = pending_n;

  function automatic int frame_dim(input int reg_val, input int cap);
    int d;
    d = reg_val - (reg_val % 2);
    if (d < 2) d = 2;
    if (d > cap) d = cap;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic predict_downscale(input bds_pkg::pixel_in_t px);
    int                         w;
    int                         h;
    bds_pkg::pair_sum_t         pair;
    bds_pkg::pair_sum_t         stored;
    logic [bds_pkg::QUAD_W-1:0] sb;
    logic [bds_pkg::QUAD_W-1:0] sg;
    logic [bds_pkg::QUAD_W-1:0] sr;
    bds_pkg::pixel_out_t        quad;
    w = frame_dim(int'(width_reg), bds_pkg::WIDTH_LIMIT);
    h = frame_dim(int'(height_reg), bds_pkg::HEIGHT_LIMIT);
    if (!col[0]) begin
      left_px = px;
    end else begin
      pair.blue  = bds_pkg::SUM_W'(px.in_blue) + bds_pkg::SUM_W'(left_px.in_blue);
      pair.green = bds_pkg::SUM_W'(px.in_green) + bds_pkg::SUM_W'(left_px.in_green);
      pair.red   = bds_pkg::SUM_W'(px.in_red) + bds_pkg::SUM_W'(left_px.in_red);
      if (!row[0]) begin
        pair_line[col[bds_pkg::CNT_W-1:1]] = pair;
      end else begin
        stored = pair_line[col[bds_pkg::CNT_W-1:1]];
        sb = bds_pkg::QUAD_W'(pair.blue) + bds_pkg::QUAD_W'(stored.blue);
        sg = bds_pkg::QUAD_W'(pair.green) + bds_pkg::QUAD_W'(stored.green);
        sr = bds_pkg::QUAD_W'(pair.red) + bds_pkg::QUAD_W'(stored.red);
        quad.out_blue  = sb[bds_pkg::QUAD_W-1:2];
        quad.out_green = sg[bds_pkg::QUAD_W-1:2];
        quad.out_red   = sr[bds_pkg::QUAD_W-1:2];
        quad.frame_end = (int'(col) == w - 1) && (int'(row) == h - 1);
        expected_quads.push_back(quad);
      end
    end
    // A counter left beyond a bound that has just shrunk wraps on its next advance.
    if (int'(col) + 1 >= w) begin
      col = '0;
      if (int'(row) + 1 >= h) row = '0;
      else row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [bds_pkg::PIX_W-1:0] got,
                             input logic [bds_pkg::PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result beat %0d: %s is %0d, expected %0d",
                                quads_seen, name, got, want));
  endtask

  task automatic check_quad(input bds_pkg::pixel_out_t got);
    bds_pkg::pixel_out_t want;
    if (expected_quads.size() == 0) begin
      report_mismatch($sformatf("result beat %0d arrived with none expected (%h)",
                                quads_seen, got));
    end else begin
      want = expected_quads.pop_front();
      check_field("out_blue", got.out_blue, want.out_blue);
      check_field("out_green", got.out_green, want.out_green);
      check_field("out_red", got.out_red, want.out_red);
      check_field("frame_end", bds_pkg::PIX_W'(got.frame_end),
                  bds_pkg::PIX_W'(want.frame_end));
    end
    quads_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = bds_pkg::WIDTH_RESET;
      height_reg = bds_pkg::HEIGHT_RESET;
      col        = '0;
      row        = '0;
      left_px    = '0;
      expected_quads.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bds_pkg::REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
          end
          bds_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (pixel_valid && pixel_ready) predict_downscale(pixel);
      if (result_valid && result_ready) check_quad(result);
    end
    pending_n = expected_quads.size();
  end

endmodule

// ===== tb/box_downscale_2x2_bgr_core_tb.sv =====
module box_downscale_2x2_bgr_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [bds_pkg::CFG_IDX_W-1:0] REG_SPARE = bds_pkg::CFG_IDX_W'(3);

  logic                          clk;
  logic                          rst;
  logic                          pixel_valid;
  logic                          pixel_ready;
  bds_pkg::pixel_in_t            pixel;
  logic                          result_valid;
  logic                          result_ready;
  bds_pkg::pixel_out_t           result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bds_pkg::SIZE_W-1:0]    cfg_data;
  int                            fail_count;
  int                            quads_pending;
  int                            send_idle_pct;
  int                            recv_idle_pct;
  logic                          hold_req;
  logic                          hold_done;

  box_downscale_2x2_bgr_core DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  box_downscale_2x2_bgr_core_checker quad_check (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .quads_pending(quads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bds_pkg::pixel_in_t rand_pixel();
    bds_pkg::pixel_in_t px;
    px.in_blue  = bds_pkg::PIX_W'($urandom_range(0, 255));
    px.in_green = bds_pkg::PIX_W'($urandom_range(0, 255));
    px.in_red   = bds_pkg::PIX_W'($urandom_range(0, 255));
    return px;
  endfunction

  task automatic send_pixel(input bds_pkg::pixel_in_t px);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (!pixel_ready);
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic settle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (quads_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bds_pkg::SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    result_ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int rand_items;
    int fw_eff;
    int fh_eff;
    logic [bds_pkg::SIZE_W-1:0] h_reg;
    rst           = 1'b1;
    pixel_valid   = 1'b0;
    pixel         = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 20;
    recv_idle_pct = 54;
    hold_req      = 1'b0;
    rand_items    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Oversized sizes, then a tiny frame taken up while the column count is past it.
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(4095));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(4095));
    send_pixels(2);
    settle();
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(2));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(0));
    send_pixels(3);

    settle();
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(3));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(2));
    write_reg(REG_SPARE, bds_pkg::SIZE_W'(4095));
    repeat (4) send_pixel(bds_pkg::pixel_in_t'{8'd255, 8'd255, 8'd255});
    repeat (3) send_pixel(bds_pkg::pixel_in_t'{8'd1, 8'd255, 8'd3});
    send_pixel(bds_pkg::pixel_in_t'{8'd0, 8'd254, 8'd2});

    // Narrow the frame while the column count sits beyond the new width.
    settle();
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(8));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(2));
    send_pixels(14);
    settle();
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(4));
    send_pixels(1);

    // Likewise for the row count and a shortened frame.
    settle();
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(2));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(4));
    send_pixels(4);
    settle();
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(2));
    send_pixels(2);

    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end else if (rand_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 20;
      end
      if ($urandom_range(0, 11) == 0) begin
        fw_eff = 2 * $urandom_range(9, 100);
        fh_eff = 2;
      end else begin
        fw_eff = 2 * $urandom_range(1, 8);
        fh_eff = 2 * $urandom_range(1, 5);
      end
      if (fh_eff == 2) h_reg = bds_pkg::SIZE_W'($urandom_range(0, 3));
      else h_reg = bds_pkg::SIZE_W'(fh_eff + $urandom_range(0, 1));
      settle();
      write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(fw_eff + $urandom_range(0, 1)));
      write_reg(bds_pkg::REG_FRAME_HEIGHT, h_reg);
      send_pixels(fw_eff * fh_eff);
      rand_items += fw_eff * fh_eff;
    end

    settle();
    if (fail_count == 0 && quads_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
